[rtl/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, constants and address-step functions for the character LCD
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int unsigned BusyW       = 14;
  localparam int unsigned AddrW       = 7;
  localparam int unsigned DispDepth   = 128;
  localparam int unsigned GlyphDepth  = 64;
  localparam int unsigned GlyphAddrW  = 6;
  localparam int unsigned GlyphW      = 5;

  localparam logic [BusyW-1:0] ShortBusyRst = 14'd273;
  localparam logic [BusyW-1:0] LongBusyRst  = 14'd11207;
  localparam logic [7:0]       SpaceChar    = 8'h20;
  localparam logic [7:0]       BusyReadData = 8'hFF;

  localparam logic [AddrW-1:0] Line1End   = 7'h27;
  localparam logic [AddrW-1:0] Line2Start = 7'h40;
  localparam logic [AddrW-1:0] Line2End   = 7'h67;
  localparam logic [7:0]       OneLineLen = 8'd80;
  localparam logic [7:0]       OneLineLenX2 = 8'd160;
  localparam logic [5:0]       ViewLen    = 6'd40;

  // item modes
  localparam logic [2:0] ModeTime   = 3'd0;
  localparam logic [2:0] ModeCmd    = 3'd1;
  localparam logic [2:0] ModeDWrite = 3'd2;
  localparam logic [2:0] ModeStatus = 3'd3;
  localparam logic [2:0] ModeDRead  = 3'd4;

  // config register indexes
  localparam logic RegShortBusy = 1'b0;
  localparam logic RegLongBusy  = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  value;
    logic [15:0] elapsed_cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_ignored;
    logic       busy_flag;
    logic [6:0] current_address;
    logic       glyph_ram_selected;
    logic       display_on;
    logic       cursor_on;
    logic       blink_on;
    logic [5:0] view_shift;
  } result_t;

  typedef struct packed {
    logic load;     // latch a new request
    logic exec;     // execute the latched request
    logic rd_done;  // RAM read data is valid, finish the data read
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_go;    // latched request is a data read that will be served
  } dp_status_t;

  function automatic logic [AddrW-1:0] next_addr(logic [AddrW-1:0] a, logic glyph,
                                                 logic two_line, logic fwd);
    logic [7:0]            s;
    logic [AddrW-1:0]      r;
    logic [GlyphAddrW-1:0] g;
    s = '0;
    r = a;
    g = a[GlyphAddrW-1:0] + (fwd ? 6'd1 : 6'd63);
    if (glyph) begin
      r = {1'b0, g};
    end else if (two_line) begin
      if (fwd && a == Line1End)        r = Line2Start;
      else if (fwd && a == Line2End)   r = '0;
      else if (!fwd && a == Line2Start) r = Line1End;
      else if (!fwd && a == '0)        r = Line2End;
      else                             r = a + (fwd ? 7'd1 : 7'd127);
    end else begin
      // one-line space; an address set beyond 79 still folds back mod 80
      s = {1'b0, a} + (fwd ? 8'd1 : 8'd79);
      if (s >= OneLineLenX2)    s = s - OneLineLenX2;
      else if (s >= OneLineLen) s = s - OneLineLen;
      r = s[AddrW-1:0];
    end
    return r;
  endfunction

  function automatic logic [5:0] next_shift(logic [5:0] s, logic fwd);
    logic [6:0] t;
    t = {1'b0, s} + (fwd ? 7'd1 : 7'd39);
    if (t >= {1'b0, ViewLen}) t = t - {1'b0, ViewLen};
    return t[5:0];
  endfunction

endpackage

`default_nettype wire

[rtl/clcd_ram.sv]
// ----------------------------------------------------------------------------
// clcd_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[rtl/clcd_ctrl.sv]
// ----------------------------------------------------------------------------
// clcd_ctrl
// Request sequencer: accept, execute, and the RAM read state for a served data read.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl import clcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StExec  = 3'b010,
    StRdata = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.rd_go ? StRdata : StIdle;
      end
      StRdata: begin
        cmd_o.rd_done = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/clcd_datapath.sv]
// ----------------------------------------------------------------------------
// clcd_datapath
// Controller registers, display/glyph RAMs, busy countdown and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_datapath import clcd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_cmd_t        cmd_i,
  input  wire item_t            item_i,
  input  wire logic [BusyW-1:0] short_busy_i,
  input  wire logic [BusyW-1:0] long_busy_i,
  output dp_status_t            status_o,
  output result_t               result_o,
  output logic                  result_valid_o
);

  item_t            item_q;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             glyph_q, glyph_d;
  logic             two_line_q, two_line_d;
  logic [5:0]       shift_q, shift_d;
  logic             inc_q, inc_d;
  logic             scroll_q, scroll_d;
  logic [2:0]       flags_q, flags_d;
  logic [BusyW-1:0] busy_q, busy_d;
  logic [DispDepth-1:0]  disp_vld_q, disp_vld_d;
  logic [GlyphDepth-1:0] glyph_vld_q, glyph_vld_d;
  result_t          result_q, result_d;
  logic             result_valid_q, result_valid_d;

  logic              disp_we, glyph_we;
  logic [7:0]        disp_rdata;
  logic [GlyphW-1:0] glyph_rdata;
  logic              busy_nz;
  logic [7:0]        rd;
  logic              ign;
  logic [7:0]        v;

  clcd_ram #(.Width(8), .Depth(DispDepth)) u_disp_ram (
    .clk_i   (clk_i),
    .we_i    (disp_we),
    .addr_i  (addr_q),
    .wdata_i (item_q.value),
    .rdata_o (disp_rdata)
  );

  clcd_ram #(.Width(GlyphW), .Depth(GlyphDepth)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .addr_i  (addr_q[GlyphAddrW-1:0]),
    .wdata_i (item_q.value[GlyphW-1:0]),
    .rdata_o (glyph_rdata)
  );

  assign busy_nz        = (busy_q != '0);
  assign v              = item_q.value;
  assign status_o.rd_go = (item_q.mode == ModeDRead) && !busy_nz;

  always_comb begin
    addr_d         = addr_q;
    glyph_d        = glyph_q;
    two_line_d     = two_line_q;
    shift_d        = shift_q;
    inc_d          = inc_q;
    scroll_d       = scroll_q;
    flags_d        = flags_q;
    busy_d         = busy_q;
    disp_vld_d     = disp_vld_q;
    glyph_vld_d    = glyph_vld_q;
    disp_we        = 1'b0;
    glyph_we       = 1'b0;
    rd             = '0;
    ign            = 1'b0;
    result_d       = result_q;
    result_valid_d = 1'b0;

    if (cmd_i.exec) begin
      unique case (item_q.mode)
        ModeTime: begin
          if ({2'b00, busy_q} <= item_q.elapsed_cycles) busy_d = '0;
          else busy_d = busy_q - item_q.elapsed_cycles[BusyW-1:0];
        end
        ModeCmd: begin
          if (busy_nz) begin
            ign = 1'b1;
          end else begin
            busy_d = short_busy_i;
            priority if (v[7]) begin            // set display address
              addr_d  = v[6:0];
              glyph_d = 1'b0;
            end else if (v[6]) begin            // set glyph address
              addr_d  = {1'b0, v[5:0]};
              glyph_d = 1'b1;
            end else if (v[5]) begin            // function set
              two_line_d = v[3];
            end else if (v[4]) begin            // cursor / display shift
              if (v[3]) shift_d = next_shift(shift_q, !v[2]);
              else      addr_d  = next_addr(addr_q, glyph_q, two_line_q, v[2]);
            end else if (v[3]) begin            // display control
              flags_d = v[2:0];
            end else if (v[2]) begin            // entry mode
              inc_d    = v[1];
              scroll_d = v[0];
            end else if (v[1]) begin            // home
              addr_d  = '0;
              glyph_d = 1'b0;
              shift_d = '0;
              busy_d  = long_busy_i;
            end else if (v[0]) begin            // clear: invalid entries read as spaces
              disp_vld_d = '0;
              addr_d     = '0;
              glyph_d    = 1'b0;
              shift_d    = '0;
              inc_d      = 1'b1;
              busy_d     = long_busy_i;
            end else begin
              // no-op, short busy only
            end
          end
        end
        ModeDWrite: begin
          if (busy_nz) begin
            ign = 1'b1;
          end else begin
            busy_d = short_busy_i;
            if (glyph_q) begin
              glyph_we = 1'b1;
              glyph_vld_d[addr_q[GlyphAddrW-1:0]] = 1'b1;
            end else begin
              disp_we = 1'b1;
              disp_vld_d[addr_q] = 1'b1;
            end
            addr_d = next_addr(addr_q, glyph_q, two_line_q, inc_q);
            if (!glyph_q && scroll_q) shift_d = next_shift(shift_q, inc_q);
          end
        end
        ModeStatus: rd = {busy_nz, addr_q};
        ModeDRead: begin
          // served read finishes after the RAM read cycle
          if (busy_nz) rd = BusyReadData;
        end
        default: ;
      endcase
    end

    if (cmd_i.rd_done) begin
      if (glyph_q) begin
        rd = glyph_vld_q[addr_q[GlyphAddrW-1:0]] ? {3'b000, glyph_rdata} : '0;
      end else begin
        rd = disp_vld_q[addr_q] ? disp_rdata : SpaceChar;
      end
      addr_d = next_addr(addr_q, glyph_q, two_line_q, inc_q);
      busy_d = short_busy_i;
    end

    if ((cmd_i.exec && !status_o.rd_go) || cmd_i.rd_done) begin
      result_valid_d              = 1'b1;
      result_d.read_data          = rd;
      result_d.write_ignored      = ign;
      result_d.busy_flag          = (busy_d != '0);
      result_d.current_address    = addr_d;
      result_d.glyph_ram_selected = glyph_d;
      result_d.display_on         = flags_d[2];
      result_d.cursor_on          = flags_d[1];
      result_d.blink_on           = flags_d[0];
      result_d.view_shift         = shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q         <= '0;
      glyph_q        <= 1'b0;
      two_line_q     <= 1'b0;
      shift_q        <= '0;
      inc_q          <= 1'b1;
      scroll_q       <= 1'b0;
      flags_q        <= '0;
      busy_q         <= '0;
      disp_vld_q     <= '0;
      glyph_vld_q    <= '0;
      result_valid_q <= 1'b0;
    end else begin
      addr_q         <= addr_d;
      glyph_q        <= glyph_d;
      two_line_q     <= two_line_d;
      shift_q        <= shift_d;
      inc_q          <= inc_d;
      scroll_q       <= scroll_d;
      flags_q        <= flags_d;
      busy_q         <= busy_d;
      disp_vld_q     <= disp_vld_d;
      glyph_vld_q    <= glyph_vld_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

`default_nettype wire

[rtl/character_lcd_controller_top.sv]
// ----------------------------------------------------------------------------
// character_lcd_controller_top
// Character LCD controller: APB busy-length registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Sequence: start is latched in Idle and executed in Exec; the result strobe
//   is registered. A served data read adds the Rdata state for the registered
//   read port of the display/glyph RAMs. A new start is taken only in Idle.
// Reset: busy lengths 273/11207; display RAM reads as spaces and glyph rows as
//   zero through per-entry valid flags, so no clearing pass. No output stall.
`default_nettype none

module character_lcd_controller_top import clcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item_i,
  output result_t          result_o,
  output logic             result_valid_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [BusyW-1:0] short_busy_q, long_busy_q;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             reg_sel;
  logic             cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = (reg_sel == RegLongBusy) ? {18'd0, long_busy_q} : {18'd0, short_busy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_busy_q <= ShortBusyRst;
      long_busy_q  <= LongBusyRst;
    end else if (cfg_we) begin
      if (reg_sel == RegShortBusy) short_busy_q <= pwdata[BusyW-1:0];
      else                         long_busy_q  <= pwdata[BusyW-1:0];
    end
  end

  clcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  clcd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .short_busy_i   (short_busy_q),
    .long_busy_i    (long_busy_q),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

[tb/sv/character_lcd_controller_top_test.sv]
// ----------------------------------------------------------------------------
// character_lcd_controller_top_test
// Self-checking bench for the character LCD controller. A short directed table
// hits the busy rules, unused modes and the address wrap edges, then random
// bus traffic runs under four busy-length settings and several start gap
// patterns. Every result is checked field by field against a local model, or
// against the reply typed into the table for pinned rows.
module character_lcd_controller_top_test;
  import clcd_pkg::*;

  // command byte opcodes, highest set bit selects the command
  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdHome    = 8'h02;
  localparam logic [7:0] CmdEntry   = 8'h04;
  localparam logic [7:0] CmdDisplay = 8'h08;
  localparam logic [7:0] CmdShift   = 8'h10;
  localparam logic [7:0] CmdFunc    = 8'h20;
  localparam logic [7:0] CmdCgAddr  = 8'h40;
  localparam logic [7:0] CmdDdAddr  = 8'h80;

  localparam logic [2:0] ModeUnusedLo = 3'd5;
  localparam logic [2:0] ModeUnusedHi = 3'd7;

  localparam int unsigned RandomPerPhase = 120;

  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [31:0] reg_val;
    item_t       ev;
    bit          pinned;
    result_t     reply;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       item_d;
  result_t     result_q;
  logic        result_valid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // expectation typed into the plan, travels with the request
  logic        pinned_use;
  result_t     pinned_reply;

  result_t     replies_due[$];
  plan_row_t   plan[$];
  int unsigned idle_pct;
  int unsigned n_fail;
  int unsigned n_events;
  int unsigned n_results;
  int unsigned n_dropped;

  // controller model state
  logic [7:0]  disp_mem[DispDepth];
  logic [4:0]  glyph_mem[GlyphDepth];
  logic [6:0]  ac;
  bit          gsel;
  bit          two_ln;
  logic [5:0]  vshift;
  bit          incr;
  bit          scroll;
  logic [2:0]  dflags;
  int unsigned busy_left;
  int unsigned short_len;
  int unsigned long_len;

  character_lcd_controller_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_d),
    .result_o       (result_q),
    .result_valid_o (result_valid),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2400000;
    $display("timeout with %0d results outstanding", replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic void lcd_reset();
    foreach (disp_mem[i]) disp_mem[i] = SpaceChar;
    foreach (glyph_mem[i]) glyph_mem[i] = '0;
    ac        = '0;
    gsel      = 1'b0;
    two_ln    = 1'b0;
    vshift    = '0;
    incr      = 1'b1;
    scroll    = 1'b0;
    dflags    = '0;
    busy_left = 0;
    short_len = 32'(ShortBusyRst);
    long_len  = 32'(LongBusyRst);
  endfunction

  function automatic void step_addr(bit fwd);
    int unsigned a;
    a = ac;
    if (gsel) begin
      a = (a + (fwd ? 1 : 63)) % 64;
    end else if (two_ln) begin
      // only the line edges jump, the gap wraps through the full space
      if (fwd && a == Line1End)        a = Line2Start;
      else if (fwd && a == Line2End)   a = 0;
      else if (!fwd && a == Line2Start) a = Line1End;
      else if (!fwd && a == 0)         a = Line2End;
      else                             a = (a + (fwd ? 1 : 127)) % 128;
    end else begin
      a = (a + (fwd ? 1 : 79)) % 80;
    end
    ac = a[6:0];
  endfunction

  function automatic void step_view(bit fwd);
    int unsigned s;
    s = (vshift + (fwd ? 1 : 39)) % 40;
    vshift = s[5:0];
  endfunction

  function automatic void run_command(logic [7:0] v);
    busy_left = short_len;
    if (v & CmdDdAddr) begin
      ac   = v[6:0];
      gsel = 1'b0;
    end else if (v & CmdCgAddr) begin
      ac   = {1'b0, v[5:0]};
      gsel = 1'b1;
    end else if (v & CmdFunc) begin
      two_ln = v[3];
    end else if (v & CmdShift) begin
      if (v[3]) step_view(!v[2]);
      else step_addr(v[2]);
    end else if (v & CmdDisplay) begin
      dflags = v[2:0];
    end else if (v & CmdEntry) begin
      incr   = v[1];
      scroll = v[0];
    end else if (v & CmdHome) begin
      ac        = '0;
      gsel      = 1'b0;
      vshift    = '0;
      busy_left = long_len;
    end else if (v & CmdClear) begin
      foreach (disp_mem[i]) disp_mem[i] = SpaceChar;
      ac        = '0;
      gsel      = 1'b0;
      vshift    = '0;
      incr      = 1'b1;
      busy_left = long_len;
    end
  endfunction

  function automatic void store_data(logic [7:0] v);
    busy_left = short_len;
    if (gsel) glyph_mem[ac[5:0]] = v[4:0];
    else disp_mem[ac] = v;
    step_addr(incr);
    if (!gsel && scroll) step_view(incr);
  endfunction

  function automatic result_t apply_bus_event(item_t it);
    result_t r;
    r = '0;
    case (it.mode)
      ModeTime: begin
        busy_left = (it.elapsed_cycles >= busy_left) ? 0 : busy_left - it.elapsed_cycles;
      end
      ModeCmd, ModeDWrite: begin
        if (busy_left != 0) r.write_ignored = 1'b1;
        else if (it.mode == ModeCmd) run_command(it.value);
        else store_data(it.value);
      end
      ModeStatus: begin
        r.read_data = {busy_left != 0, ac};
      end
      ModeDRead: begin
        if (busy_left != 0) begin
          r.read_data = BusyReadData;
        end else begin
          r.read_data = gsel ? {3'b000, glyph_mem[ac[5:0]]} : disp_mem[ac];
          step_addr(incr);
          busy_left = short_len;
        end
      end
      default: ;
    endcase
    r.busy_flag          = busy_left != 0;
    r.current_address    = ac;
    r.glyph_ram_selected = gsel;
    r.display_on         = dflags[2];
    r.cursor_on          = dflags[1];
    r.blink_on           = dflags[0];
    r.view_shift         = vshift;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_reply(result_t want, result_t got);
    report("read_data", want.read_data, got.read_data);
    report("write_ignored", want.write_ignored, got.write_ignored);
    report("busy_flag", want.busy_flag, got.busy_flag);
    report("current_address", want.current_address, got.current_address);
    report("glyph_ram_selected", want.glyph_ram_selected, got.glyph_ram_selected);
    report("display_on", want.display_on, got.display_on);
    report("cursor_on", want.cursor_on, got.cursor_on);
    report("blink_on", want.blink_on, got.blink_on);
    report("view_shift", want.view_shift, got.view_shift);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (result_valid) begin
        n_results++;
        if (replies_due.size() == 0) begin
          n_fail++;
          $display("%0t: result with no request outstanding, expected none, got %p",
                   $time, result_q);
        end else begin
          check_reply(replies_due.pop_front(), result_q);
        end
      end
      if (start && !busy) begin
        want = apply_bus_event(item_d);
        if (pinned_use) want = pinned_reply;
        if (want.write_ignored) n_dropped++;
        replies_due.push_back(want);
        n_events++;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_event(item_t it, bit pin, result_t pexp);
    start        <= 1'b1;
    item_d       <= it;
    pinned_use   <= pin;
    pinned_reply <= pexp;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegShortBusy) short_len = 32'(val[BusyW-1:0]);
    else long_len = 32'(val[BusyW-1:0]);
    @(posedge clk_i);
    // read back the same register
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {{(32-BusyW){1'b0}}, val[BusyW-1:0]}) begin
      n_fail++;
      $display("%0t: prdata mismatch at reg %0d, expected 0x%0h, got 0x%0h",
               $time, idx, val[BusyW-1:0], prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic void add_event(logic [2:0] m, logic [7:0] v, logic [15:0] el);
    plan_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: 1'b0, reg_val: '0, ev: '{m, v, el}, pinned: 1'b0,
          reply: '0};
    plan.push_back(r);
  endfunction

  function automatic void add_pinned(logic [2:0] m, logic [7:0] v, logic [15:0] el,
                                     logic [7:0] rd, logic ign, logic bsy, logic [6:0] a);
    plan_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: 1'b0, reg_val: '0, ev: '{m, v, el}, pinned: 1'b1,
          reply: '0};
    r.reply.read_data       = rd;
    r.reply.write_ignored   = ign;
    r.reply.busy_flag       = bsy;
    r.reply.current_address = a;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic idx, logic [31:0] val);
    plan_row_t r;
    r = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, ev: '0, pinned: 1'b0, reply: '0};
    plan.push_back(r);
  endfunction

  function automatic logic [7:0] random_command();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(9))
      0: return CmdDdAddr | b[6:0];
      1: return CmdCgAddr | b[5:0];
      2: return CmdFunc | b[4:0];
      3: return CmdShift | b[3:0];
      4: return CmdDisplay | b[2:0];
      5: return CmdEntry | b[1:0];
      6: return CmdHome | b[0];
      7: return CmdClear;
      8: return 8'h00;
      default: return b;
    endcase
  endfunction

  function automatic logic [15:0] random_elapsed();
    case ($urandom_range(3))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(400));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_traffic(int unsigned n);
    item_t       it;
    int unsigned k;
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      it.value          = 8'($urandom);
      it.elapsed_cycles = 16'($urandom);
      k = $urandom_range(99);
      if (k < 20) begin
        it.mode           = ModeTime;
        it.elapsed_cycles = random_elapsed();
      end else if (k < 45) begin
        it.mode  = ModeCmd;
        it.value = random_command();
      end else if (k < 72) begin
        it.mode = ModeDWrite;
      end else if (k < 82) begin
        it.mode = ModeStatus;
      end else if (k < 96) begin
        it.mode = ModeDRead;
      end else begin
        it.mode = 3'($urandom_range(ModeUnusedLo, ModeUnusedHi));
      end
      send_event(it, 1'b0, '0);
      sent++;
      // mostly let the busy countdown run out before the next access
      if (it.mode != ModeTime && $urandom_range(3) != 0) begin
        it.mode           = ModeTime;
        it.elapsed_cycles = random_elapsed();
        send_event(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_d       = '0;
    pinned_use   = 1'b0;
    pinned_reply = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_pct     = 0;
    n_fail       = 0;
    n_events     = 0;
    n_results    = 0;
    n_dropped    = 0;
    lcd_reset();

    // busy rules at the reset busy lengths
    add_pinned(ModeStatus, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 7'h00);
    add_pinned(ModeDRead,  8'h00, 16'h0000, SpaceChar, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeStatus, 8'h00, 16'h0000, 8'h81, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeDRead,  8'h00, 16'h0000, BusyReadData, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeCmd,    8'hFF, 16'h0000, 8'h00, 1'b1, 1'b1, 7'h01);
    add_pinned(ModeDWrite, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b1, 7'h01);
    add_pinned(ModeUnusedLo, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeUnusedHi, 8'hFF, 16'hFFFF, 8'h00, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeTime,   8'h00, 16'd272, 8'h00, 1'b0, 1'b1, 7'h01);
    add_pinned(ModeTime,   8'hFF, 16'd1,   8'h00, 1'b0, 1'b0, 7'h01);
    // zero busy lengths; upper write bits must be dropped
    add_cfg(RegShortBusy, 32'hFFFF_C000);
    add_cfg(RegLongBusy,  32'h0000_0000);
    add_event(ModeCmd,    8'h00, 16'h0000);
    add_event(ModeCmd,    CmdDisplay | 8'h07, 16'h0000);
    add_event(ModeCmd,    CmdFunc | 8'h08, 16'h0000);
    add_event(ModeCmd,    CmdDdAddr | 8'h27, 16'h0000);
    add_event(ModeDWrite, 8'hFF, 16'h0000);
    add_event(ModeCmd,    CmdEntry | 8'h01, 16'h0000);
    add_event(ModeDWrite, 8'h00, 16'h0000);
    add_event(ModeCmd,    CmdDdAddr, 16'h0000);
    add_event(ModeDWrite, 8'h5A, 16'h0000);
    add_event(ModeDRead,  8'h00, 16'h0000);
    add_event(ModeCmd,    CmdShift | 8'h0C, 16'h0000);
    add_event(ModeCmd,    CmdCgAddr | 8'h3F, 16'h0000);
    add_event(ModeCmd,    CmdEntry | 8'h02, 16'h0000);
    add_event(ModeDWrite, 8'hFF, 16'h0000);
    add_event(ModeCmd,    CmdCgAddr | 8'h3F, 16'h0000);
    add_event(ModeDRead,  8'h00, 16'h0000);
    add_event(ModeCmd,    CmdClear, 16'h0000);
    add_event(ModeCmd,    CmdFunc, 16'h0000);
    add_event(ModeCmd,    CmdDdAddr | 8'h55, 16'h0000);
    add_event(ModeDWrite, 8'hA5, 16'h0000);
    add_cfg(RegShortBusy, 32'h0000_3FFF);
    add_cfg(RegLongBusy,  32'h0000_3FFF);
    add_event(ModeCmd,    CmdHome, 16'h0000);
    add_event(ModeTime,   8'h00, 16'hFFFF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        reg_write(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_event(plan[i].ev, plan[i].pinned, plan[i].reply);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          reg_write(RegShortBusy, 32'(ShortBusyRst));
          reg_write(RegLongBusy, 32'(LongBusyRst));
          idle_pct = 0;
        end
        1: begin
          reg_write(RegShortBusy, 32'd0);
          reg_write(RegLongBusy, 32'd0);
          idle_pct = 63;
        end
        2: begin
          reg_write(RegShortBusy, 32'h3FFF);
          reg_write(RegLongBusy, 32'h3FFF);
          idle_pct = 0;
        end
        default: begin
          reg_write(RegShortBusy, $urandom_range(1, 64));
          reg_write(RegLongBusy, $urandom_range(16383));
          idle_pct = 32;
        end
      endcase
      send_random_traffic(RandomPerPhase);
    end

    wait_drained();
    $display("Checked %0d results for %0d bus requests (%0d writes dropped while busy),",
             n_results, n_events, n_dropped);
    $display("across reset, zero, maximum and random busy lengths with and without gaps.");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
